// ===== src/hbl_pkg.sv =====
package hbl_pkg;

    localparam int CoordW = 32;
    localparam int HtW    = 32;
    localparam int CntW   = 9;
    localparam int WgtW   = 17;
    localparam int CmpW   = 13;

    localparam logic [WgtW-1:0] WgtOne = 17'h10000;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        CFG_WEST  = 3'd0,
        CFG_NORTH = 3'd1,
        CFG_INV_W = 3'd2,
        CFG_INV_L = 3'd3,
        CFG_ROWS  = 3'd4,
        CFG_COLS  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic            outside;
        logic [WgtW-1:0] wx;
        logic [WgtW-1:0] wy;
    } t_wgt;

endpackage

// ===== src/hbl_front.sv =====
module hbl_front #(
    parameter int MAX_ROWS = 256,
    parameter int MAX_COLS = 256,
    parameter int RW = 8,
    parameter int CW = 8,
    parameter int RCW = 9,
    parameter int CCW = 9
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic                             i_ready,
    input  hbl_pkg::t_op                     i_op,
    input  logic [7:0]                       i_row,
    input  logic [7:0]                       i_col,
    input  logic signed [hbl_pkg::HtW-1:0]   i_height,
    input  logic signed [hbl_pkg::CoordW-1:0] i_x,
    input  logic signed [hbl_pkg::CoordW-1:0] i_y,
    input  logic [31:0]                      i_west,
    input  logic [31:0]                      i_north,
    input  logic [31:0]                      i_inv_w,
    input  logic [31:0]                      i_inv_l,
    input  logic [RCW-1:0]                   i_rows,
    input  logic [CCW-1:0]                   i_cols,
    output logic                             o_valid,
    output hbl_pkg::t_op                     o_op,
    output logic                             o_wok,
    output logic [RW-1:0]                    o_wrow,
    output logic [CW-1:0]                    o_wcol,
    output logic signed [hbl_pkg::HtW-1:0]   o_height,
    output logic [RW-1:0]                    o_r,
    output logic [CW-1:0]                    o_c,
    output hbl_pkg::t_wgt                    o_wgt
);
    import hbl_pkg::*;

    typedef struct packed {
        logic            out;
        logic [CmpW-1:0] pos;
        logic [WgtW-1:0] w;
    } t_cell;

    function automatic t_cell map_cell(input logic [63:0] g, input logic [CmpW-1:0] cnt);
        t_cell     res;
        logic [27:0] ip;
        ip = g[63:36];
        res.out = (ip > 28'(cnt)) || ((ip == 28'(cnt)) && (g[35:0] != 36'd0));
        if (ip >= 28'(cnt - 13'd1)) begin
            res.pos = cnt - 13'd2;
            res.w   = WgtOne;
        end else begin
            res.pos = ip[CmpW-1:0];
            res.w   = {1'b0, g[35:20]};
        end
        return res;
    endfunction

    logic [3:0] r_v;
    logic [3:0] en;

    t_op                    r_op [4];
    logic                   r_wok [4];
    logic [RW-1:0]          r_wrow [4];
    logic [CW-1:0]          r_wcol [4];
    logic signed [HtW-1:0]  r_ht [4];

    logic [31:0] r_x, r_y;
    logic        r_neg1, r_neg2;
    logic [31:0] r_dx, r_dy;
    logic [63:0] r_gx, r_gy;
    logic [RW-1:0] r_r;
    logic [CW-1:0] r_c;
    t_wgt          r_wgt;

    logic [32:0] n_dx, n_dy;
    t_cell       cx, cy;

    always_comb begin
        en[3] = !r_v[3] || i_ready;
        en[2] = !r_v[2] || en[3];
        en[1] = !r_v[1] || en[2];
        en[0] = !r_v[0] || en[1];
    end
    assign o_ready = en[0];

    assign n_dx = {r_x[31], r_x} - {i_west[31], i_west};
    assign n_dy = {i_north[31], i_north} - {r_y[31], r_y};
    assign cx = map_cell(r_gx, CmpW'(i_cols));
    assign cy = map_cell(r_gy, CmpW'(i_rows));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            if (en[1]) r_v[1] <= r_v[0];
            if (en[2]) r_v[2] <= r_v[1];
            if (en[3]) r_v[3] <= r_v[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_op[0]   <= i_op;
            r_wok[0]  <= ({5'd0, i_row} < 13'(MAX_ROWS)) && ({5'd0, i_col} < 13'(MAX_COLS));
            r_wrow[0] <= RW'(i_row);
            r_wcol[0] <= CW'(i_col);
            r_ht[0]   <= i_height;
            r_x       <= i_x;
            r_y       <= i_y;
        end
        for (int k = 1; k < 4; k++) begin
            if (en[k]) begin
                r_op[k]   <= r_op[k-1];
                r_wok[k]  <= r_wok[k-1];
                r_wrow[k] <= r_wrow[k-1];
                r_wcol[k] <= r_wcol[k-1];
                r_ht[k]   <= r_ht[k-1];
            end
        end
        if (en[1]) begin
            r_neg1 <= n_dx[32] || n_dy[32];
            r_dx   <= n_dx[31:0];
            r_dy   <= n_dy[31:0];
        end
        if (en[2]) begin
            r_neg2 <= r_neg1;
            r_gx   <= r_dx * i_inv_w;
            r_gy   <= r_dy * i_inv_l;
        end
        if (en[3]) begin
            r_wgt.outside <= r_neg2 || cx.out || cy.out;
            r_wgt.wx      <= cx.w;
            r_wgt.wy      <= cy.w;
            r_c           <= CW'(cx.pos);
            r_r           <= RW'(cy.pos);
        end
    end

    assign o_valid  = r_v[3];
    assign o_op     = r_op[3];
    assign o_wok    = r_wok[3];
    assign o_wrow   = r_wrow[3];
    assign o_wcol   = r_wcol[3];
    assign o_height = r_ht[3];
    assign o_r      = r_r;
    assign o_c      = r_c;
    assign o_wgt    = r_wgt;

endmodule

// ===== src/hbl_store.sv =====
module hbl_store #(
    parameter int RW = 8,
    parameter int CW = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_ready,
    input  hbl_pkg::t_op                   i_op,
    input  logic                           i_wok,
    input  logic [RW-1:0]                  i_wrow,
    input  logic [CW-1:0]                  i_wcol,
    input  logic signed [hbl_pkg::HtW-1:0] i_height,
    input  logic [RW-1:0]                  i_r,
    input  logic [CW-1:0]                  i_c,
    input  hbl_pkg::t_wgt                  i_wgt,
    output logic                           o_valid,
    output logic signed [hbl_pkg::HtW-1:0] o_h00,
    output logic signed [hbl_pkg::HtW-1:0] o_h01,
    output logic signed [hbl_pkg::HtW-1:0] o_h10,
    output logic signed [hbl_pkg::HtW-1:0] o_h11,
    output hbl_pkg::t_wgt                  o_wgt
);
    import hbl_pkg::*;

    localparam int AW = RW - 1 + CW - 1;
    localparam int BD = 2 ** AW;

    logic         en;
    logic         r_v;
    logic         r_r0, r_c0;
    t_wgt         r_wgt;
    logic [HtW-1:0] w_rd [4];

    assign en = !r_v || i_ready;
    assign o_ready = en;

    for (genvar b = 0; b < 4; b++) begin : g_bank
        localparam logic BR = 1'(b >> 1);
        localparam logic BC = 1'(b & 1);
        logic [HtW-1:0] r_mem [BD];
        logic [HtW-1:0] r_rd;
        logic [RW-1:0]  rrow;
        logic [CW-1:0]  rcol;
        logic [AW-1:0]  raddr, waddr;
        logic           we;

        assign rrow  = (i_r[0] == BR) ? i_r : i_r + RW'(1);
        assign rcol  = (i_c[0] == BC) ? i_c : i_c + CW'(1);
        assign raddr = {rrow[RW-1:1], rcol[CW-1:1]};
        assign waddr = {i_wrow[RW-1:1], i_wcol[CW-1:1]};
        assign we    = en && i_valid && (i_op == OP_WRITE) && i_wok
                       && (i_wrow[0] == BR) && (i_wcol[0] == BC);

        always_ff @(posedge i_clk) begin
            if (we) r_mem[waddr] <= i_height;
            if (en) r_rd <= r_mem[raddr];
        end
        assign w_rd[b] = r_rd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (en) begin
            r_v <= i_valid && (i_op == OP_QUERY);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_r0  <= i_r[0];
            r_c0  <= i_c[0];
            r_wgt <= i_wgt;
        end
    end

    assign o_valid = r_v;
    assign o_h00 = w_rd[{r_r0, r_c0}];
    assign o_h01 = w_rd[{r_r0, !r_c0}];
    assign o_h10 = w_rd[{!r_r0, r_c0}];
    assign o_h11 = w_rd[{!r_r0, !r_c0}];
    assign o_wgt = r_wgt;

endmodule

// ===== src/hbl_blend.sv =====
module hbl_blend (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_ready,
    input  logic signed [hbl_pkg::HtW-1:0] i_h00,
    input  logic signed [hbl_pkg::HtW-1:0] i_h01,
    input  logic signed [hbl_pkg::HtW-1:0] i_h10,
    input  logic signed [hbl_pkg::HtW-1:0] i_h11,
    input  hbl_pkg::t_wgt                  i_wgt,
    output logic                           o_valid,
    output logic signed [hbl_pkg::HtW-1:0] o_height,
    output logic                           o_outside
);
    import hbl_pkg::*;

    logic [2:0] r_v;
    logic [2:0] en;

    logic signed [48:0] r_top, r_bot;
    logic [WgtW-1:0]    r_wy;
    logic               r_out1, r_out2, r_out3;
    logic signed [63:0] r_sum;
    logic signed [HtW-1:0] r_ht;

    logic [WgtW-1:0]    wx1, wy1;
    logic signed [48:0] n_top, n_bot;
    logic signed [63:0] n_sum, rnd;

    always_comb begin
        en[2] = !r_v[2] || i_ready;
        en[1] = !r_v[1] || en[2];
        en[0] = !r_v[0] || en[1];
    end
    assign o_ready = en[0];

    assign wx1   = WgtOne - i_wgt.wx;
    assign wy1   = WgtOne - r_wy;
    assign n_top = i_h00 * $signed({1'b0, wx1}) + i_h01 * $signed({1'b0, i_wgt.wx});
    assign n_bot = i_h10 * $signed({1'b0, wx1}) + i_h11 * $signed({1'b0, i_wgt.wx});
    assign n_sum = r_top * $signed({1'b0, wy1}) + r_bot * $signed({1'b0, r_wy});
    assign rnd   = r_sum + 64'sh8000_0000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            if (en[1]) r_v[1] <= r_v[0];
            if (en[2]) r_v[2] <= r_v[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_top  <= n_top;
            r_bot  <= n_bot;
            r_wy   <= i_wgt.wy;
            r_out1 <= i_wgt.outside;
        end
        if (en[1]) begin
            r_sum  <= n_sum;
            r_out2 <= r_out1;
        end
        if (en[2]) begin
            r_ht   <= r_out2 ? '0 : rnd[63:32];
            r_out3 <= r_out2;
        end
    end

    assign o_valid   = r_v[2];
    assign o_height  = r_ht;
    assign o_outside = r_out3;

endmodule

// ===== src/heightmap_bilinear_lookup.sv =====
// Channel  Handshake                  Payload
// in       i_in_valid / o_in_ready    i_operation, i_row_index, i_col_index, i_height_in,
//                                     i_x_coord, i_y_coord
// out      o_out_valid / i_out_ready  o_height_out, o_outside
// cfg      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One transaction per cycle on every channel while its ready is high; a query result
// passes through 8 registered stages (4 address, 1 grid read, 3 blend).
// The grid sits in four parity banks so the four corners come out of one read port each.
// Reset clears only pipeline valids and loads config defaults; the grid holds garbage until written.
// Each stage advances when empty or when its successor advances, so bubbles close up.
module heightmap_bilinear_lookup #(
    parameter int MAX_ROWS = 256,
    parameter int MAX_COLS = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_operation,
    input  logic [7:0]                      i_row_index,
    input  logic [7:0]                      i_col_index,
    input  logic signed [hbl_pkg::HtW-1:0]  i_height_in,
    input  logic signed [hbl_pkg::CoordW-1:0] i_x_coord,
    input  logic signed [hbl_pkg::CoordW-1:0] i_y_coord,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic signed [hbl_pkg::HtW-1:0]  o_height_out,
    output logic                            o_outside,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [2:0]                      i_cfg_index,
    input  logic [31:0]                     i_cfg_data
);
    import hbl_pkg::*;

    localparam int RW  = ($clog2(MAX_ROWS) < 2) ? 2 : $clog2(MAX_ROWS);
    localparam int CW  = ($clog2(MAX_COLS) < 2) ? 2 : $clog2(MAX_COLS);
    localparam int RCW = $clog2(MAX_ROWS + 1);
    localparam int CCW = $clog2(MAX_COLS + 1);

    logic [31:0]     r_west, r_north, r_inv_w, r_inv_l;
    logic [CntW-1:0] r_rows, r_cols;
    logic [RCW-1:0]  rows_c;
    logic [CCW-1:0]  cols_c;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_west  <= '0;
            r_north <= '0;
            r_inv_w <= 32'h0001_0000;
            r_inv_l <= 32'h0001_0000;
            r_rows  <= 9'd256;
            r_cols  <= 9'd256;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_WEST:  r_west  <= i_cfg_data;
                CFG_NORTH: r_north <= i_cfg_data;
                CFG_INV_W: r_inv_w <= i_cfg_data;
                CFG_INV_L: r_inv_l <= i_cfg_data;
                CFG_ROWS:  r_rows  <= i_cfg_data[CntW-1:0];
                CFG_COLS:  r_cols  <= i_cfg_data[CntW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (CmpW'(r_rows) < CmpW'(2))             rows_c = RCW'(2);
        else if (CmpW'(r_rows) > CmpW'(MAX_ROWS)) rows_c = RCW'(MAX_ROWS);
        else                                      rows_c = RCW'(r_rows);
        if (CmpW'(r_cols) < CmpW'(2))             cols_c = CCW'(2);
        else if (CmpW'(r_cols) > CmpW'(MAX_COLS)) cols_c = CCW'(MAX_COLS);
        else                                      cols_c = CCW'(r_cols);
    end

    logic               f_valid, s_ready;
    t_op                f_op;
    logic               f_wok;
    logic [RW-1:0]      f_wrow, f_r;
    logic [CW-1:0]      f_wcol, f_c;
    logic signed [HtW-1:0] f_height;
    t_wgt               f_wgt;

    logic               s_valid, b_ready;
    logic signed [HtW-1:0] s_h00, s_h01, s_h10, s_h11;
    t_wgt               s_wgt;

    hbl_front #(
        .MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS),
        .RW(RW), .CW(CW), .RCW(RCW), .CCW(CCW)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_ready (s_ready),
        .i_op    (t_op'(i_operation)),
        .i_row   (i_row_index),
        .i_col   (i_col_index),
        .i_height(i_height_in),
        .i_x     (i_x_coord),
        .i_y     (i_y_coord),
        .i_west  (r_west),
        .i_north (r_north),
        .i_inv_w (r_inv_w),
        .i_inv_l (r_inv_l),
        .i_rows  (rows_c),
        .i_cols  (cols_c),
        .o_valid (f_valid),
        .o_op    (f_op),
        .o_wok   (f_wok),
        .o_wrow  (f_wrow),
        .o_wcol  (f_wcol),
        .o_height(f_height),
        .o_r     (f_r),
        .o_c     (f_c),
        .o_wgt   (f_wgt)
    );

    hbl_store #(.RW(RW), .CW(CW)) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (s_ready),
        .i_ready (b_ready),
        .i_op    (f_op),
        .i_wok   (f_wok),
        .i_wrow  (f_wrow),
        .i_wcol  (f_wcol),
        .i_height(f_height),
        .i_r     (f_r),
        .i_c     (f_c),
        .i_wgt   (f_wgt),
        .o_valid (s_valid),
        .o_h00   (s_h00),
        .o_h01   (s_h01),
        .o_h10   (s_h10),
        .o_h11   (s_h11),
        .o_wgt   (s_wgt)
    );

    hbl_blend u_blend (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_valid),
        .o_ready  (b_ready),
        .i_ready  (i_out_ready),
        .i_h00    (s_h00),
        .i_h01    (s_h01),
        .i_h10    (s_h10),
        .i_h11    (s_h11),
        .i_wgt    (s_wgt),
        .o_valid  (o_out_valid),
        .o_height (o_height_out),
        .o_outside(o_outside)
    );

endmodule

// ===== tb/sv/height_lookup_checker.sv =====
`timescale 1ns / 1ps

module height_lookup_checker
    import hbl_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic                     i_in_ready,
    input  logic                     i_operation,
    input  logic [7:0]               i_row_index,
    input  logic [7:0]               i_col_index,
    input  logic signed [HtW-1:0]    i_height_in,
    input  logic signed [CoordW-1:0] i_x_coord,
    input  logic signed [CoordW-1:0] i_y_coord,
    input  logic                     i_out_valid,
    input  logic                     i_out_ready,
    input  logic signed [HtW-1:0]    i_height_out,
    input  logic                     i_outside,
    input  logic                     i_cfg_valid,
    input  logic                     i_cfg_ready,
    input  logic [2:0]               i_cfg_index,
    input  logic [31:0]              i_cfg_data,
    output int                       o_errors,
    output int                       o_pending,
    output int                       o_results,
    output int                       o_outside_hits
);

    typedef struct packed {
        logic signed [HtW-1:0] height;
        logic                  outside;
    } t_lookup;

    logic signed [HtW-1:0] grid_heights [0:65535];
    logic signed [31:0]    west_q, north_q;
    logic [31:0]           inv_w_q, inv_l_q;
    logic [CntW-1:0]       rows_q, cols_q;
    t_lookup               expected_q [$];

    function automatic int clamp_count(logic [CntW-1:0] v);
        if (v < 2) return 2;
        if (v > 256) return 256;
        return int'(v);
    endfunction

    // returns 1 when the point falls beyond the far border
    function automatic bit locate(longint unsigned g, int cnt, output int pos,
                                  output longint wgt);
        longint unsigned ip;
        longint unsigned rem;
        ip   = g >> 36;
        rem  = g & 64'hF_FFFF_FFFF;
        pos  = 0;
        wgt  = 0;
        if (ip > cnt || (ip == cnt && rem != 0)) return 1;
        if (ip >= cnt - 1) begin
            pos = cnt - 2;
            wgt = 65536;
        end else begin
            pos = int'(ip);
            wgt = longint'((g >> 20) & 64'hFFFF);
        end
        return 0;
    endfunction

    function automatic longint grid_at(int r, int c);
        return longint'(grid_heights[r * 256 + c]);
    endfunction

    function automatic t_lookup blend_height(logic signed [31:0] x, logic signed [31:0] y);
        t_lookup          res;
        longint           dx, dy, wx, wy, top, bot, acc;
        int               r, c;
        logic signed [64:0] rounded;
        dx  = longint'(x) - longint'(west_q);
        dy  = longint'(north_q) - longint'(y);
        res = '{height: '0, outside: 1'b1};
        if (dx < 0 || dy < 0) return res;
        if (locate(longint'(dx) * longint'({32'd0, inv_w_q}), clamp_count(cols_q), c, wx))
            return res;
        if (locate(longint'(dy) * longint'({32'd0, inv_l_q}), clamp_count(rows_q), r, wy))
            return res;
        top = grid_at(r, c) * (65536 - wx) + grid_at(r, c + 1) * wx;
        bot = grid_at(r + 1, c) * (65536 - wx) + grid_at(r + 1, c + 1) * wx;
        acc = top * (65536 - wy) + bot * wy;
        // round half up
        rounded = $signed({acc[63], acc}) + 65'sd2147483648;
        res.height  = rounded[63:32];
        res.outside = 1'b0;
        return res;
    endfunction

    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        t_lookup exp_r;
        if (!i_rst_n) begin
            west_q         <= '0;
            north_q        <= '0;
            inv_w_q        <= 32'd65536;
            inv_l_q        <= 32'd65536;
            rows_q         <= 9'd256;
            cols_q         <= 9'd256;
            o_errors       <= 0;
            o_results      <= 0;
            o_outside_hits <= 0;
            expected_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_WEST:  west_q  <= i_cfg_data;
                    CFG_NORTH: north_q <= i_cfg_data;
                    CFG_INV_W: inv_w_q <= i_cfg_data;
                    CFG_INV_L: inv_l_q <= i_cfg_data;
                    CFG_ROWS:  rows_q  <= i_cfg_data[CntW-1:0];
                    CFG_COLS:  cols_q  <= i_cfg_data[CntW-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                o_results <= o_results + 1;
                if (expected_q.size() == 0) begin
                    o_errors <= o_errors + 1;
                    if (o_errors < 10)
                        $display("ERROR: unexpected result transaction: h=%0d out=%0b",
                                 i_height_out, i_outside);
                end else begin
                    exp_r = expected_q.pop_front();
                    if (exp_r.outside) o_outside_hits <= o_outside_hits + 1;
                    if (exp_r.height !== i_height_out || exp_r.outside !== i_outside) begin
                        o_errors <= o_errors + 1;
                        if (o_errors < 10)
                            $display({"ERROR: lookup mismatch: expected h=%0d out=%0b,",
                                      " got h=%0d out=%0b"},
                                     exp_r.height, exp_r.outside, i_height_out, i_outside);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (t_op'(i_operation) == OP_WRITE)
                    grid_heights[int'(i_row_index) * 256 + int'(i_col_index)] = i_height_in;
                else
                    expected_q.push_back(blend_height(i_x_coord, i_y_coord));
            end
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import hbl_pkg::*;

    localparam int SETTLE = 16;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid, o_in_ready;
    logic              i_operation;
    logic [7:0]        i_row_index, i_col_index;
    logic signed [31:0] i_height_in, i_x_coord, i_y_coord;
    logic              o_out_valid;
    logic              i_out_ready = 1'b1;
    logic signed [31:0] o_height_out;
    logic              o_outside;
    logic              i_cfg_valid, o_cfg_ready;
    logic [2:0]        i_cfg_index;
    logic [31:0]       i_cfg_data;

    int errors, pending, results, outside_hits;
    int writes_sent, burst_left;
    int stall_cnt = 0;

    bit          written_map [0:65535];
    logic [31:0] west_m, north_m, inv_w_m, inv_l_m;
    int          rows_m, cols_m;

    always #5 i_clk = ~i_clk;

    heightmap_bilinear_lookup dut (.*);

    height_lookup_checker u_checker (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_ready(o_in_ready), .i_operation,
        .i_row_index, .i_col_index, .i_height_in, .i_x_coord, .i_y_coord,
        .i_out_valid(o_out_valid), .i_out_ready, .i_height_out(o_height_out),
        .i_outside(o_outside), .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index,
        .i_cfg_data, .o_errors(errors), .o_pending(pending), .o_results(results),
        .o_outside_hits(outside_hits)
    );

    // receiver stall pattern: free-flowing, light, heavy and periodic windows
    always @(posedge i_clk) begin
        stall_cnt <= stall_cnt + 1;
        case (stall_cnt[9:8])
            2'd0: i_out_ready <= 1'b1;
            2'd1: i_out_ready <= ($urandom % 4) != 0;
            2'd2: i_out_ready <= 1'($urandom % 2);
            default: i_out_ready <= stall_cnt[2:0] != 0;
        endcase
    end

    initial begin
        #5ms;
        $display("FAIL heightmap_bilinear_lookup");
        $finish;
    end

    task automatic send_item(t_op op, logic [7:0] row, logic [7:0] col,
                             logic [31:0] h, logic [31:0] x, logic [31:0] y);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_row_index <= row;
        i_col_index <= col;
        i_height_in <= h;
        i_x_coord   <= x;
        i_y_coord   <= y;
        forever begin
            @(negedge i_clk);
            if (o_in_ready) break;
        end
        @(posedge i_clk);
        burst_left--;
        if (op == OP_WRITE) begin
            written_map[int'(row) * 256 + int'(col)] = 1'b1;
            writes_sent++;
        end
    endtask

    task automatic write_height(int row, int col, logic [31:0] h);
        send_item(OP_WRITE, row[7:0], col[7:0], h, $urandom, $urandom);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        burst_left = 0;
        forever begin
            @(negedge i_clk);
            if (pending == 0) break;
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        forever begin
            @(negedge i_clk);
            if (o_cfg_ready) break;
        end
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_WEST:  west_m  = data;
            CFG_NORTH: north_m = data;
            CFG_INV_W: inv_w_m = data;
            CFG_INV_L: inv_l_m = data;
            CFG_ROWS:  rows_m  = (data[8:0] < 2) ? 2 : (data[8:0] > 256) ? 256 : int'(data[8:0]);
            CFG_COLS:  cols_m  = (data[8:0] < 2) ? 2 : (data[8:0] > 256) ? 256 : int'(data[8:0]);
            default: ;
        endcase
    endtask

    // stimulus guard: 1 = beyond border, 0 = inside with pos set
    function automatic bit axis_cell(longint d, logic [31:0] inv, int cnt, output int pos);
        longint unsigned g, ip;
        pos = 0;
        if (d < 0) return 1;
        g  = longint'(d) * longint'({32'd0, inv});
        ip = g >> 36;
        if (ip > cnt || (ip == cnt && (g & 64'hF_FFFF_FFFF) != 0)) return 1;
        pos = (ip >= cnt - 1) ? cnt - 2 : int'(ip);
        return 0;
    endfunction

    function automatic bit corners_ready(logic [31:0] x, logic [31:0] y);
        int r, c;
        if (axis_cell(longint'($signed(x)) - longint'($signed(west_m)), inv_w_m, cols_m, c))
            return 1;
        if (axis_cell(longint'($signed(north_m)) - longint'($signed(y)), inv_l_m, rows_m, r))
            return 1;
        return written_map[r * 256 + c] && written_map[r * 256 + c + 1] &&
               written_map[(r + 1) * 256 + c] && written_map[(r + 1) * 256 + c + 1];
    endfunction

    function automatic longint offset_for(logic [31:0] inv, int span);
        longint unsigned g;
        if ($urandom % 8 == 0) return longint'($signed($urandom)) * 2;
        if (inv == 0) return longint'($urandom_range(0, 1 << 22));
        g = ({32'd0, 32'($urandom_range(0, span))} << 36) | {28'd0, $urandom, 4'($urandom)};
        return longint'(g / inv);
    endfunction

    task automatic query_random(int span);
        longint      dx, dy, xx, yy;
        logic [31:0] x, y;
        dx = offset_for(inv_w_m, span);
        dy = offset_for(inv_l_m, span);
        xx = longint'($signed(west_m)) + dx;
        yy = longint'($signed(north_m)) - dy;
        x  = (xx > 64'sh7FFF_FFFF || xx < -64'sh8000_0000) ? $urandom : xx[31:0];
        y  = (yy > 64'sh7FFF_FFFF || yy < -64'sh8000_0000) ? $urandom : yy[31:0];
        if (!corners_ready(x, y)) begin
            // border corner always maps to the written north-west cell
            x = west_m;
            y = north_m;
        end
        send_item(OP_QUERY, 8'($urandom), 8'($urandom), $urandom, x, y);
    endtask

    task automatic run_phase(logic [31:0] west, logic [31:0] north, logic [31:0] inv_w,
                             logic [31:0] inv_l, logic [31:0] rows, logic [31:0] cols);
        int span, n;
        drain();
        write_reg(CFG_WEST, west);
        write_reg(CFG_NORTH, north);
        write_reg(CFG_INV_W, inv_w);
        write_reg(CFG_INV_L, inv_l);
        write_reg(CFG_ROWS, rows);
        write_reg(CFG_COLS, cols);
        span = (rows_m < cols_m ? rows_m : cols_m);
        n    = span > 10 ? 10 : span;
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
                write_height(r, c, $urandom);
        for (int k = 0; k < 220; k++) begin
            case ($urandom % 10)
                0: write_height($urandom_range(0, n - 1), $urandom_range(0, n - 1), $urandom);
                1: write_height($urandom_range(0, 255), $urandom_range(0, 255), $urandom);
                default: query_random(n + 1);
            endcase
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_operation = OP_WRITE;
        i_row_index = '0;
        i_col_index = '0;
        i_height_in = '0;
        i_x_coord   = '0;
        i_y_coord   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_WEST;
        i_cfg_data  = '0;
        burst_left  = 0;
        writes_sent = 0;
        west_m  = 0;
        north_m = 0;
        inv_w_m = 32'd65536;
        inv_l_m = 32'd65536;
        rows_m  = 256;
        cols_m  = 256;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset geometry: one-degree cells, borders at zero
        write_height(0, 0, 32'h7FFF_FFFF);
        write_height(0, 1, 32'h8000_0000);
        write_height(1, 0, 32'hFFFF_FFFF);
        write_height(1, 1, 32'd0);
        write_height(0, 2, 32'd12345);
        write_height(1, 2, -32'sd777);
        write_height(254, 254, 32'h8000_0000);
        write_height(254, 255, 32'd256);
        write_height(255, 254, 32'h7FFF_FFFF);
        write_height(255, 255, -32'sd513);
        send_item(OP_QUERY, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'd0, 32'd0);
        send_item(OP_QUERY, 8'h00, 8'h00, 32'd0, 32'd1 << 19, -(32'sd1 << 19));
        send_item(OP_QUERY, 8'h5A, 8'hA5, 32'd0, 32'h0014_0000, -32'sh000C_0000);
        send_item(OP_QUERY, 8'h00, 8'h00, 32'd0, 32'd255 << 20, -(32'sd255 << 20));
        send_item(OP_QUERY, 8'h00, 8'h00, 32'd0, 32'd256 << 20, -(32'sd256 << 20));
        send_item(OP_QUERY, 8'h00, 8'h00, 32'd0, (32'd256 << 20) + 1, -32'sd1);
        send_item(OP_QUERY, 8'h00, 8'h00, 32'd0, -32'sd1, -32'sd1);
        send_item(OP_QUERY, 8'h00, 8'h00, 32'd0, 32'd0, 32'd1);
        send_item(OP_QUERY, 8'h00, 8'h00, 32'd0, 32'h7FFF_FFFF, 32'd0);
        send_item(OP_QUERY, 8'h00, 8'h00, 32'd0, 32'd0, 32'h8000_0000);
        send_item(OP_QUERY, 8'h00, 8'h00, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF);

        run_phase(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd2, 32'd2);
        run_phase($urandom, $urandom, $urandom_range(1 << 12, 1 << 22),
                  $urandom_range(1 << 12, 1 << 22), $urandom_range(2, 12), $urandom_range(2, 12));
        run_phase(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd1);
        run_phase(-32'sd3 << 20, 32'd5 << 20, 32'd65536, 32'd131072, 32'hFFFF_FFFF, 32'd300);
        run_phase($urandom, $urandom, $urandom, $urandom, 32'd256, 32'd7);
        run_phase(32'd0, 32'd0, $urandom_range(1 << 14, 1 << 20), 32'd65536,
                  32'd9, {23'($urandom), 9'd256});
        run_phase($urandom, $urandom, $urandom_range(1 << 10, 1 << 24),
                  $urandom_range(1 << 10, 1 << 24), $urandom_range(2, 12), $urandom_range(2, 12));
        drain();

        $display("Covered %0d grid writes and %0d lookup results (%0d outside the map)",
                 writes_sent, results, outside_hits);
        $display("over eight geometry settings including border and count extremes");
        if (errors == 0 && pending == 0) begin
            $display("PASS heightmap_bilinear_lookup");
        end else begin
            $display("FAIL heightmap_bilinear_lookup");
        end
        $finish;
    end

endmodule
